// File: rtl/pwlsp_pkg.sv
// package: shared types and constants of the setpoint profile generator
`timescale 1ns / 1ps
package pwlsp_pkg;

    // default table depth
    localparam int PWLSP_MAX_SEG = 16;

    // field widths
    localparam int TEMP_W  = 16;
    localparam int RAMP_W  = 16;
    localparam int TIME_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;
    localparam int CIDX_W  = 1;
    localparam int CDATA_W = 16;

    // cell index compare width, covers up to 128 cells
    localparam int CELL_IDX_W = 7;

    // interpolation datapath widths
    localparam int P1_W  = TEMP_W + RAMP_W + 1;
    localparam int P2_W  = TEMP_W + RAMP_W + 2;
    localparam int NUM_W = P2_W + 1;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    // action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_STARTING_TEMP = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_SEGMENT_COUNT = 1'b1;

    // query token walking along the cell chain
    typedef struct packed {
        logic                     valid;
        logic                     hit;
        logic [TIME_W-1:0]        t;
        logic signed [TEMP_W-1:0] start;
        logic signed [TEMP_W-1:0] target;
        logic [RAMP_W-1:0]        ramp;
    } t_tok;

    // slot write broadcast to the cells
    typedef struct packed {
        logic                     en;
        logic [SLOT_W-1:0]        slot;
        logic [RAMP_W-1:0]        ramp;
        logic signed [TEMP_W-1:0] target;
    } t_wr;

endpackage

// File: rtl/pwlsp_if.sv
// interfaces: item, result and configuration channels
`timescale 1ns / 1ps

interface pwlsp_item_if import pwlsp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [SLOT_W-1:0]        slot;
    logic [RAMP_W-1:0]        ramp_time;
    logic signed [TEMP_W-1:0] target_temp;
    logic [TIME_W-1:0]        query_time;

    modport source (output valid, action, slot, ramp_time, target_temp, query_time,
                    input ready);
    modport sink (input valid, action, slot, ramp_time, target_temp, query_time,
                  output ready);
endinterface

interface pwlsp_res_if import pwlsp_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [TEMP_W-1:0] temperature;

    modport source (output valid, temperature, input ready);
    modport sink (input valid, temperature, output ready);
endinterface

interface pwlsp_cfg_if import pwlsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [CIDX_W-1:0]   index;
    logic [CDATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/pwlsp_cell.sv
// one segment cell: holds ramp and target, advances the query token one step
`timescale 1ns / 1ps
module pwlsp_cell import pwlsp_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_wr                i_wr,
    input  logic [COUNT_W-1:0] i_count,
    input  t_tok               i_tok,
    output t_tok               o_tok
);

    logic [RAMP_W-1:0]        r_ramp;
    logic signed [TEMP_W-1:0] r_target;
    t_tok                     r_tok;
    t_tok                     n_tok;
    logic                     w_active;
    logic                     w_sel;

    // slot storage, undefined until written
    assign w_sel = ({{(CELL_IDX_W-SLOT_W){1'b0}}, i_wr.slot} == CELL_IDX_W'(IDX));
    always_ff @(posedge i_clk) begin
        if (i_wr.en && w_sel) begin
            r_ramp   <= i_wr.ramp;
            r_target <= i_wr.target;
        end
    end

    // segment in use
    assign w_active = (CELL_IDX_W'(IDX) < {{(CELL_IDX_W-COUNT_W){1'b0}}, i_count});

    // step past the segment or stop inside it
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && !i_tok.hit && w_active) begin
            if (i_tok.t >= {{(TIME_W-RAMP_W){1'b0}}, r_ramp}) begin
                n_tok.t     = i_tok.t - {{(TIME_W-RAMP_W){1'b0}}, r_ramp};
                n_tok.start = r_target;
            end else begin
                n_tok.hit    = 1'b1;
                n_tok.target = r_target;
                n_tok.ramp   = r_ramp;
            end
        end
    end

    // hand the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/pwlsp_div.sv
// serial signed divider, one quotient bit per cycle, truncates toward zero
`timescale 1ns / 1ps
module pwlsp_div import pwlsp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [NUM_W-1:0]  i_num,
    input  logic [RAMP_W-1:0]        i_den,
    output logic                     o_done,
    output logic signed [TEMP_W-1:0] o_quo
);

    logic [NUM_W-1:0]  r_quo;
    logic [RAMP_W-1:0] r_rem;
    logic [RAMP_W-1:0] r_den;
    logic              r_neg;
    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [RAMP_W:0]   w_shift;
    logic              w_ge;
    logic [RAMP_W-1:0] w_sub;
    logic [NUM_W-1:0]  w_res;

    // restoring step, the difference fits the remainder width whenever it is taken
    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_den});
    assign w_sub   = w_shift[RAMP_W-1:0] - r_den;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: load magnitude, then shift quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[NUM_W-1];
            r_quo <= i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub : w_shift[RAMP_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    // apply sign
    assign w_res  = r_neg ? (~r_quo + 1'b1) : r_quo;
    assign o_quo  = w_res[TEMP_W-1:0];
    assign o_done = r_done;

endmodule

// File: rtl/piecewise_linear_setpoint_profile_top.sv
// top level: ramp/soak setpoint generator over a chain of segment cells
//
//  channel   dir  modport  payload
//  i_item    in   sink     action, slot, ramp_time, target_temp, query_time
//  o_res     out  source   temperature
//  i_cfg     in   sink     index, data
//
// a slot write is stored in its cell when it is accepted. a query walks the token
// through MAX_SEGMENTS cells, one per cycle, then passes the multiply, sum and
// load states (ST_MUL, ST_ADD, ST_LOAD), the serial divider (one bit per cycle)
// and the output register; without interpolation it goes straight from the walk
// to the output register. one item at a time; a new item is taken while a
// result still waits on o_res. reset is synchronous, active low.
`timescale 1ns / 1ps
module piecewise_linear_setpoint_profile_top import pwlsp_pkg::*; #(
    parameter int MAX_SEGMENTS = PWLSP_MAX_SEG
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pwlsp_item_if.sink   i_item,
    pwlsp_res_if.source  o_res,
    pwlsp_cfg_if.sink    i_cfg
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_WALK = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_ADD  = 7'b0001000,
        ST_LOAD = 7'b0010000,
        ST_DIV  = 7'b0100000,
        ST_HOLD = 7'b1000000
    } t_state;

    t_state                   r_state;
    t_state                   n_state;
    logic signed [TEMP_W-1:0] r_start_temp;
    logic [COUNT_W-1:0]       r_count;
    logic signed [TEMP_W-1:0] r_s;
    logic signed [TEMP_W-1:0] r_e;
    logic [RAMP_W-1:0]        r_r;
    logic [RAMP_W-1:0]        r_t;
    logic signed [P1_W-1:0]   r_p1;
    logic signed [P2_W-1:0]   r_p2;
    logic signed [NUM_W-1:0]  r_num;
    logic signed [TEMP_W-1:0] r_res;
    logic                     r_out_valid;
    logic signed [TEMP_W-1:0] r_out_temp;
    logic                     w_in_acc;
    logic                     w_out_acc;
    logic                     w_div_done;
    logic signed [TEMP_W-1:0] w_div_quo;
    t_wr                      w_wr;
    t_tok                     w_tok [MAX_SEGMENTS+1];
    t_tok                     w_end;

    // configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_temp <= '0;
            r_count      <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_STARTING_TEMP: r_start_temp <= $signed(i_cfg.data[TEMP_W-1:0]);
                CFG_SEGMENT_COUNT: r_count      <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // input transaction
    assign i_item.ready = (r_state == ST_IDLE);
    assign w_in_acc     = i_item.valid && i_item.ready;

    // slot write broadcast
    assign w_wr.en     = w_in_acc && (i_item.action == ACT_WRITE);
    assign w_wr.slot   = i_item.slot;
    assign w_wr.ramp   = i_item.ramp_time;
    assign w_wr.target = i_item.target_temp;

    // token injection at the head of the chain
    assign w_tok[0].valid  = w_in_acc && (i_item.action == ACT_QUERY);
    assign w_tok[0].hit    = 1'b0;
    assign w_tok[0].t      = i_item.query_time;
    assign w_tok[0].start  = r_start_temp;
    assign w_tok[0].target = '0;
    assign w_tok[0].ramp   = '0;

    // segment cell chain
    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        pwlsp_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end
    assign w_end = w_tok[MAX_SEGMENTS];

    // serial divider
    pwlsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_LOAD),
        .i_num   (r_num),
        .i_den   (r_r),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_in_acc && (i_item.action == ACT_QUERY)) n_state = ST_WALK;
            ST_WALK: if (w_end.valid) n_state = w_end.hit ? ST_MUL : ST_HOLD;
            ST_MUL:  n_state = ST_ADD;
            ST_ADD:  n_state = ST_LOAD;
            ST_LOAD: n_state = ST_DIV;
            ST_DIV:  if (w_div_done) n_state = ST_HOLD;
            ST_HOLD: if (!r_out_valid || o_res.ready) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // interpolation datapath
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WALK) && w_end.valid) begin
            r_s   <= w_end.start;
            r_e   <= w_end.target;
            r_r   <= w_end.ramp;
            r_t   <= w_end.t[RAMP_W-1:0];
            r_res <= w_end.start;
        end
        if (r_state == ST_MUL) begin
            r_p1 <= P1_W'(r_s * $signed({1'b0, r_r}));
            r_p2 <= P2_W'(($signed({r_e[TEMP_W-1], r_e}) - $signed({r_s[TEMP_W-1], r_s}))
                          * $signed({1'b0, r_t}));
        end
        if (r_state == ST_ADD) begin
            r_num <= NUM_W'(r_p1) + NUM_W'(r_p2);
        end
        if ((r_state == ST_DIV) && w_div_done) begin
            r_res <= w_div_quo;
        end
    end

    // output register
    assign w_out_acc = r_out_valid && o_res.ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_HOLD) && (!r_out_valid || o_res.ready)) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_HOLD) && (!r_out_valid || o_res.ready)) begin
            r_out_temp <= r_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.temperature = r_out_temp;

endmodule
